// ----- hdl/cht_pkg.sv -----
// shared types and constants for the chained hash table
// no dependencies; imported by every module of the block but cht_ram
package cht_pkg;

	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int BUCKETS_DEF = 64;
	localparam int NODES_DEF   = 64;
	// key bits folded into the remainder per cycle when the bucket count is not a power of two
	localparam int DIGIT_BITS  = 8;

	typedef enum logic [0:0] {
		REQ_ADD    = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NULLKEY  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic    accept;
		logic    clear_wr;
		logic    commit;
		logic    walk_sel;
		logic    res_set;
		status_t res_status;
		logic    res_take_value;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic clear_last;
		logic is_add;
		logic key_null;
		logic pool_full;
		logic head_null;
		logic node_match;
		logic link_null;
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/cht_ram.sv -----
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module cht_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/cht_mod.sv -----
// bucket index unit: key modulo the bucket count
// depends on cht_pkg; a mask for powers of two, otherwise a radix-2 remainder loop
module cht_mod #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int BW      = $clog2(BUCKETS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cht_pkg::KEY_W-1:0] key,
	output logic                     done,
	output logic [BW-1:0]            rem
);

	import cht_pkg::*;

	localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			logic [BW-1:0] rem_q;

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= key[BW-1:0];
				end
			end

			assign done = 1'b1;
			assign rem  = rem_q;
		end else begin : g_iter
			localparam int STEPS = KEY_W / DIGIT_BITS;
			localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
			localparam logic [BW:0] BK = (BW + 1)'(BUCKETS);

			logic [KEY_W-1:0] sh_q;
			logic [BW-1:0]    r_q;
			logic [BW-1:0]    r_next;
			logic [CW-1:0]    cnt_q;
			logic             busy_q;

			// one conditional subtract per key bit, msb first
			always_comb begin
				logic [BW:0] t;
				r_next = r_q;
				for (int i = 0; i < DIGIT_BITS; i++) begin
					t = {r_next, sh_q[KEY_W-1-i]};
					if (t >= BK) begin
						t = t - BK;
					end
					r_next = t[BW-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(STEPS - 1)) begin
						busy_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q <= key;
					r_q  <= '0;
				end else if (busy_q) begin
					sh_q <= sh_q << DIGIT_BITS;
					r_q  <= r_next;
				end
			end

			assign done = !busy_q;
			assign rem  = r_q;
		end
	endgenerate

endmodule

// ----- hdl/cht_datapath.sv -----
// datapath of the chained hash table: request registers, bucket and node rams,
// pool counter, result and output registers; depends on cht_pkg, cht_ram, cht_mod
module cht_datapath #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int NODES   = cht_pkg::NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cht_pkg::cmd_t               cmd,
	output cht_pkg::stat_t              stat,
	input  logic                        req_type,
	input  logic [cht_pkg::KEY_W-1:0]   key_in,
	input  logic [cht_pkg::VALUE_W-1:0] value_in,
	input  logic                        out_ready,
	output logic                        out_valid,
	output cht_pkg::status_t            out_status,
	output logic [cht_pkg::VALUE_W-1:0] out_value
);

	import cht_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int AW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam int NW = KEY_W + VALUE_W + LW;
	localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic               add_q;
	logic [LW-1:0]      used_q;
	logic [BW-1:0]      clr_cnt_q;
	logic [BW-1:0]      bucket;
	logic               mod_done;

	logic               head_we;
	logic [BW-1:0]      head_waddr;
	logic [LW-1:0]      head_wdata;
	logic [LW-1:0]      head_rd;

	logic [AW-1:0]      node_raddr;
	logic [NW-1:0]      node_rd;
	logic [KEY_W-1:0]   node_key;
	logic [VALUE_W-1:0] node_value;
	logic [LW-1:0]      node_link;

	status_t            res_status_q;
	logic [VALUE_W-1:0] res_value_q;
	logic               out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q   <= key_in;
			value_q <= value_in;
			add_q   <= (req_type == REQ_ADD);
		end
	end

	cht_mod #(
		.BUCKETS (BUCKETS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.accept),
		.key    (key_in),
		.done   (mod_done),
		.rem    (bucket)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.commit) begin
				used_q <= used_q + 1'b1;
			end
			if (cmd.clear_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// bucket heads: cleared by the sweep after reset, rewritten on every add that is stored
	assign head_we    = cmd.clear_wr | cmd.commit;
	assign head_waddr = cmd.clear_wr ? clr_cnt_q : bucket;
	assign head_wdata = cmd.clear_wr ? NULL_LINK : used_q;

	cht_ram #(
		.WIDTH (LW),
		.DEPTH (BUCKETS)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bucket),
		.rdata (head_rd)
	);

	// node pool: link, value and key side by side
	assign node_raddr = cmd.walk_sel ? node_link[AW-1:0] : head_rd[AW-1:0];

	cht_ram #(
		.WIDTH (NW),
		.DEPTH (NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (used_q[AW-1:0]),
		.wdata ({head_rd, value_q, key_q}),
		.raddr (node_raddr),
		.rdata (node_rd)
	);

	assign node_key   = node_rd[KEY_W-1:0];
	assign node_value = node_rd[KEY_W+VALUE_W-1:KEY_W];
	assign node_link  = node_rd[NW-1:KEY_W+VALUE_W];

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_take_value ? node_value : '0;
		end
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_value  <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.mod_done   = mod_done;
	assign stat.clear_last = (clr_cnt_q == BW'(BUCKETS - 1));
	assign stat.is_add     = add_q;
	assign stat.key_null   = (key_q == '0);
	assign stat.pool_full  = (used_q >= NULL_LINK);
	assign stat.head_null  = (head_rd >= NULL_LINK);
	assign stat.node_match = (node_key == key_q);
	assign stat.link_null  = (node_link >= NULL_LINK);
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

// ----- hdl/cht_ctrl.sv -----
// controller state machine of the chained hash table
// depends on cht_pkg; drives the datapath through cmd_t and reads stat_t
module cht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output cht_pkg::cmd_t  cmd,
	input  cht_pkg::stat_t stat
);

	import cht_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_MOD    = 6'b000100,
		S_DECIDE = 6'b001000,
		S_WALK   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.mod_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.is_add) begin
					cmd.res_set = 1'b1;
					state_d     = S_DONE;
					priority if (stat.key_null) begin
						cmd.res_status = ST_NULLKEY;
					end else if (stat.pool_full) begin
						cmd.res_status = ST_FULL;
					end else begin
						cmd.commit     = 1'b1;
						cmd.res_status = ST_OK;
					end
				end else if (stat.head_null) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOTFOUND;
					state_d        = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_sel = 1'b1;
				priority if (stat.node_match) begin
					cmd.res_set        = 1'b1;
					cmd.res_status     = ST_OK;
					cmd.res_take_value = 1'b1;
					state_d            = S_DONE;
				end else if (stat.link_null) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_NOTFOUND;
					state_d        = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/chained_hash_table.sv -----
// top level of the chained hash table: stream ports, controller and datapath
// depends on cht_pkg, cht_ctrl, cht_datapath (and through it cht_ram, cht_mod)
//
// usage
// - slave stream carries one request per transaction: tuser selects add or
//   search, tdata holds the key and the value to store
// - master stream returns exactly one result per request, in order: tuser holds
//   the status, tdata the value found (zero for adds and misses)
// - after reset the bucket heads are swept to empty, one bucket per cycle, and
//   s_axis_tready stays low until the sweep is over
// - a request passes the remainder, decide and done states on its way to the
//   output register, with a chain walk before done for searches of a non-empty
//   bucket, and the next request is taken the cycle after; the walk visits the
//   chain nodes one per cycle through the node ram's registered read port
// - when BUCKETS is not a power of two the key remainder is worked out in the
//   remainder state by the iterative divider, 8 key bits per step
// - one request is worked on at a time; the next one is taken as soon as the
//   previous result has moved into the output register, even if the receiver
//   has not yet taken it
// - a stalled receiver holds the result in the output register; the block then
//   finishes the following request and waits until that register frees
module chained_hash_table #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int NODES   = cht_pkg::NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] key_in, [63:32] value_in
	input  logic [63:0] s_axis_tdata,
	// [0] req_type
	input  logic [0:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] value_out
	output logic [31:0] m_axis_tdata,
	// [1:0] status
	output logic [1:0]  m_axis_tuser
);

	import cht_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	status_t out_status;

	// request channel handshake lives in the controller
	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// payload fields unpacked straight from tdata and tuser
	cht_datapath #(
		.BUCKETS (BUCKETS),
		.NODES   (NODES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (s_axis_tuser[0]),
		.key_in     (s_axis_tdata[KEY_W-1:0]),
		.value_in   (s_axis_tdata[KEY_W+VALUE_W-1:KEY_W]),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (out_status),
		.out_value  (m_axis_tdata)
	);

	assign m_axis_tuser = out_status;

endmodule
